@@ sv/spp_pkg.sv @@
// Shared constants for the shuffle power permuter: sizes, field widths
// and configuration register indexes. No dependencies.
package spp_pkg;

  localparam int MAX_LEN     = 1024;
  localparam int LIFT_LEVELS = 31;

  localparam int POS_FIELD_W  = 10;
  localparam int CHAR_W       = 8;
  localparam int REPEAT_W     = 31;
  localparam int LEN_FIELD_W  = 11;
  localparam int CFG_DATA_W   = 31;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_COUNT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_LENGTH       = 1'b1;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

endpackage

@@ sv/spp_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module spp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/shuffle_power_permuter.sv @@
// Shuffle power permuter top level: byte store plus binary-lifting jump tables.
// Depends on spp_pkg and spp_ram.
//
//  channel | signals                                  | flow
//  --------+------------------------------------------+---------------------------
//  item    | start, busy, action, position, char_in   | beat when start & !busy
//  result  | done, char_out                           | one-cycle strobe, no stall
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data| beat when valid & ready
//
// A write item does not make the block busy. A read item steps through the
// jump-table levels with one lookup per set repeat bit, then one byte-store read;
// out-of-range reads answer the next cycle. Reset and every length write rebuild
// the tables, bound by the single jump-table read port. busy is high meanwhile;
// config beats are always taken. Results cannot stall.
module shuffle_power_permuter #(
  parameter int MAX_LEN     = spp_pkg::MAX_LEN,
  parameter int LIFT_LEVELS = spp_pkg::LIFT_LEVELS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               action,
  input  logic [spp_pkg::POS_FIELD_W-1:0]    position,
  input  logic [spp_pkg::CHAR_W-1:0]         char_in,
  output logic                               done,
  output logic [spp_pkg::CHAR_W-1:0]         char_out,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [spp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [spp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int POS_W    = $clog2(MAX_LEN);
  localparam int LEN_W    = $clog2(MAX_LEN + 1);
  localparam int LVL_W    = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int JT_DEPTH = LIFT_LEVELS * (2 ** POS_W);
  localparam int JT_AW    = (JT_DEPTH > 1) ? $clog2(JT_DEPTH) : 1;
  localparam int CS_AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_BUILD0  = 8'b0000_0010,
    ST_BUILD_A = 8'b0000_0100,
    ST_BUILD_B = 8'b0000_1000,
    ST_DRAIN   = 8'b0001_0000,
    ST_WALK    = 8'b0010_0000,
    ST_CHAR    = 8'b0100_0000,
    ST_EMIT    = 8'b1000_0000
  } state_t;

  state_t                   state;
  logic [spp_pkg::REPEAT_W-1:0] repeat_count;
  logic [LEN_W-1:0]         len;
  logic [LVL_W-1:0]         lvl;
  logic [POS_W-1:0]         p;
  logic [POS_W-1:0]         wp;
  logic                     wpend;
  logic [POS_W-1:0]         cur;
  logic                     pend;

  logic                     jt_wr_en;
  logic [JT_AW-1:0]         jt_wr_addr;
  logic [POS_W-1:0]         jt_wr_data;
  logic                     jt_rd_en;
  logic [JT_AW-1:0]         jt_rd_addr;
  logic [POS_W-1:0]         jt_rd_data;

  logic                     cs_wr_en;
  logic                     cs_rd_en;
  logic [spp_pkg::CHAR_W-1:0] cs_rd_data;

  logic                     accept;
  logic                     pos_ok;
  logic [POS_W-1:0]         pos_idx;
  logic [POS_W-1:0]         cur_eff;
  logic [31:0]              kx;
  logic                     kbit;
  logic [LVL_W-1:0]         lvl_prev;
  logic                     p_last;
  logic                     lvl_last;
  logic [LEN_W:0]           len_p1;
  logic [LEN_W-1:0]         half;
  logic [LEN_W-1:0]         p_ext;
  logic [LEN_W:0]           dst_w;
  logic [POS_W-1:0]         dst;
  logic [LEN_W-1:0]         len_cfg;
  logic [spp_pkg::LEN_FIELD_W-1:0] len_raw;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && (state == ST_IDLE);
  assign pos_ok    = 32'(position) < 32'(len);
  assign pos_idx   = POS_W'(position);
  assign cur_eff   = pend ? jt_rd_data : cur;
  assign kx        = {1'b0, repeat_count};
  assign kbit      = kx[5'(lvl)];
  assign lvl_prev  = LVL_W'(lvl - 1'b1);
  assign p_last    = (LEN_W'(p) == LEN_W'(len - 1'b1));
  assign lvl_last  = (lvl == LVL_W'(LIFT_LEVELS - 1));

  // Interleave map for the first level
  always_comb begin
    len_p1 = {1'b0, len} + 1'b1;
    half   = len_p1[LEN_W:1];
    p_ext  = LEN_W'(p);
    if (p_ext < half) begin
      dst_w = {p_ext, 1'b0};
    end else begin
      dst_w = {LEN_W'(len - 1'b1 - p_ext), 1'b1};
    end
    dst = POS_W'(dst_w);
  end

  always_comb begin
    len_raw = cfg_data[spp_pkg::LEN_FIELD_W-1:0];
    if (len_raw == '0) begin
      len_cfg = LEN_W'(1);
    end else if (32'(len_raw) > 32'(MAX_LEN)) begin
      len_cfg = LEN_W'(MAX_LEN);
    end else begin
      len_cfg = LEN_W'(len_raw);
    end
  end

  always_comb begin
    jt_wr_en   = 1'b0;
    jt_wr_addr = JT_AW'({lvl, wp});
    jt_wr_data = jt_rd_data;
    jt_rd_en   = 1'b0;
    jt_rd_addr = JT_AW'({lvl_prev, p});
    case (state)
      ST_BUILD0: begin
        jt_wr_en   = 1'b1;
        jt_wr_addr = JT_AW'({lvl, p});
        jt_wr_data = dst;
      end
      ST_BUILD_A: begin
        jt_wr_en = wpend;
        jt_rd_en = 1'b1;
      end
      ST_BUILD_B: begin
        jt_rd_en   = 1'b1;
        jt_rd_addr = JT_AW'({lvl_prev, jt_rd_data});
      end
      ST_DRAIN: begin
        jt_wr_en = 1'b1;
      end
      ST_WALK: begin
        jt_rd_en   = kbit;
        jt_rd_addr = JT_AW'({lvl, cur_eff});
      end
      default: begin
      end
    endcase
  end

  assign cs_wr_en = accept && (action == spp_pkg::ACT_WRITE) && pos_ok;
  assign cs_rd_en = (state == ST_CHAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_BUILD0;
      repeat_count <= '0;
      len          <= LEN_W'(1);
      lvl          <= '0;
      p            <= '0;
      wpend        <= 1'b0;
      pend         <= 1'b0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept && (action == spp_pkg::ACT_READ)) begin
            if (pos_ok) begin
              cur   <= pos_idx;
              pend  <= 1'b0;
              lvl   <= LVL_W'(LIFT_LEVELS - 1);
              state <= ST_WALK;
            end else begin
              char_out <= '0;
              done     <= 1'b1;
            end
          end
        end
        ST_BUILD0: begin
          if (p_last) begin
            p     <= '0;
            wpend <= 1'b0;
            if (LIFT_LEVELS > 1) begin
              lvl   <= LVL_W'(1);
              state <= ST_BUILD_A;
            end else begin
              state <= ST_IDLE;
            end
          end else begin
            p <= p + 1'b1;
          end
        end
        ST_BUILD_A: begin
          state <= ST_BUILD_B;
        end
        ST_BUILD_B: begin
          wp    <= p;
          wpend <= 1'b1;
          if (p_last) begin
            state <= ST_DRAIN;
          end else begin
            p     <= p + 1'b1;
            state <= ST_BUILD_A;
          end
        end
        ST_DRAIN: begin
          wpend <= 1'b0;
          p     <= '0;
          if (lvl_last) begin
            state <= ST_IDLE;
          end else begin
            lvl   <= lvl + 1'b1;
            state <= ST_BUILD_A;
          end
        end
        ST_WALK: begin
          cur  <= cur_eff;
          pend <= kbit;
          if (lvl == '0) begin
            state <= ST_CHAR;
          end else begin
            lvl <= lvl - 1'b1;
          end
        end
        ST_CHAR: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          char_out <= cs_rd_data;
          done     <= 1'b1;
          state    <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == spp_pkg::REG_REPEAT_COUNT) begin
          repeat_count <= cfg_data[spp_pkg::REPEAT_W-1:0];
        end else if (cfg_index == spp_pkg::REG_LENGTH) begin
          len   <= len_cfg;
          lvl   <= '0;
          p     <= '0;
          wpend <= 1'b0;
          state <= ST_BUILD0;
        end
      end
    end
  end

  spp_ram #(
    .WIDTH (POS_W),
    .DEPTH (JT_DEPTH)
  ) u_jump_ram (
    .clk     (clk),
    .wr_en   (jt_wr_en),
    .wr_addr (jt_wr_addr),
    .wr_data (jt_wr_data),
    .rd_en   (jt_rd_en),
    .rd_addr (jt_rd_addr),
    .rd_data (jt_rd_data)
  );

  spp_ram #(
    .WIDTH (spp_pkg::CHAR_W),
    .DEPTH (MAX_LEN)
  ) u_char_ram (
    .clk     (clk),
    .wr_en   (cs_wr_en),
    .wr_addr (CS_AW'(pos_idx)),
    .wr_data (char_in),
    .rd_en   (cs_rd_en),
    .rd_addr (CS_AW'(cur_eff)),
    .rd_data (cs_rd_data)
  );

endmodule

@@ verif/tb_shuffle_power_permuter.sv @@
// Self-checking testbench for shuffle_power_permuter: byte writes and permuted reads
// checked against an in-bench binary-lifting predictor across many length/repeat settings.
// Depends on spp_pkg and the shuffle_power_permuter RTL.
`timescale 1ns / 1ps

module tb_shuffle_power_permuter;

  localparam int POS_W  = spp_pkg::POS_FIELD_W;
  localparam int CHAR_W = spp_pkg::CHAR_W;
  localparam int DATA_W = spp_pkg::CFG_DATA_W;
  localparam int LEN_W  = spp_pkg::LEN_FIELD_W;

  typedef struct packed {
    logic                   action;
    logic [POS_W-1:0]       position;
    logic [CHAR_W-1:0]      char_in;
  } shuffle_item_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic                   action;
  logic [POS_W-1:0]       position;
  logic [CHAR_W-1:0]      char_in;
  logic                   done;
  logic [CHAR_W-1:0]      char_out;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [spp_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [DATA_W-1:0]      cfg_data;

  shuffle_power_permuter dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .position(position), .char_in(char_in), .done(done), .char_out(char_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor state
  logic [spp_pkg::REPEAT_W-1:0] rep_k;
  int                     len_n;
  logic [POS_W-1:0]       jump [spp_pkg::LIFT_LEVELS][spp_pkg::MAX_LEN];
  logic [CHAR_W-1:0]      char_mem [spp_pkg::MAX_LEN];

  // stimulus bookkeeping
  bit                     sched_filled [spp_pkg::MAX_LEN];
  shuffle_item_t          item_q [$];
  shuffle_item_t          cur_item;
  logic [CHAR_W-1:0]      char_exp_q [$];
  bit                     steady;
  int                     gap_left;
  int                     items_made;
  int                     reads_checked;
  int                     writes_seen;
  int                     reg_writes;
  int                     max_len_seen;
  int                     big_phases;
  int                     errs;

  always #5 clk = ~clk;

  function automatic void rebuild_jumps();
    int half;
    half = (len_n + 1) / 2;
    for (int p = 0; p < len_n; p++)
      jump[0][p] = (p < half) ? POS_W'(2 * p) : POS_W'(2 * (len_n - 1 - p) + 1);
    for (int lvl = 1; lvl < spp_pkg::LIFT_LEVELS; lvl++)
      for (int p = 0; p < len_n; p++)
        jump[lvl][p] = jump[lvl-1][jump[lvl-1][p]];
  endfunction

  function automatic int shuffle_target(input int p);
    logic [POS_W-1:0] cur;
    cur = POS_W'(p);
    for (int b = spp_pkg::LIFT_LEVELS - 1; b >= 0; b--)
      if (rep_k[b]) cur = jump[b][cur];
    return cur;
  endfunction

  function automatic void apply_item(input shuffle_item_t it);
    if (it.action == spp_pkg::ACT_WRITE) begin
      writes_seen++;
      if (it.position < len_n) char_mem[it.position] = it.char_in;
    end else if (it.position < len_n) begin
      char_exp_q.push_back(char_mem[shuffle_target(it.position)]);
    end else begin
      char_exp_q.push_back(8'h00);
    end
  endfunction

  function automatic void push_write(input int p, input logic [CHAR_W-1:0] c);
    shuffle_item_t it;
    it.action   = spp_pkg::ACT_WRITE;
    it.position = POS_W'(p);
    it.char_in  = c;
    item_q.push_back(it);
    if (p < len_n) sched_filled[p] = 1'b1;
    items_made++;
  endfunction

  // a read whose source byte was never stored gets a write in front of it
  function automatic void push_read(input int p);
    shuffle_item_t it;
    int t;
    if (p < len_n) begin
      t = shuffle_target(p);
      if (!sched_filled[t]) push_write(t, CHAR_W'($urandom_range(0, 255)));
    end
    it.action   = spp_pkg::ACT_READ;
    it.position = POS_W'(p);
    it.char_in  = CHAR_W'($urandom_range(0, 255));
    item_q.push_back(it);
    items_made++;
  endfunction

  task automatic report(input string what);
    $display("mismatch @%0t: %s", $time, what);
    errs++;
  endtask

  task automatic write_reg(input logic [spp_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [DATA_W-1:0] val);
    int v;
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    if (idx == spp_pkg::REG_REPEAT_COUNT) begin
      rep_k = val[spp_pkg::REPEAT_W-1:0];
    end else begin
      v = val[LEN_W-1:0];
      if (v < 1) v = 1;
      if (v > spp_pkg::MAX_LEN) v = spp_pkg::MAX_LEN;
      len_n = v;
      if (v > max_len_seen) max_len_seen = v;
      rebuild_jumps();
    end
  endtask

  // drained, then room for a trailing write beat to settle
  task automatic wait_idle();
    do @(negedge clk);
    while (item_q.size() != 0 || start || busy || char_exp_q.size() != 0);
    repeat (spp_pkg::LIFT_LEVELS + 4) @(posedge clk);
  endtask

  always @(posedge clk) begin : drive_items
    logic go;
    shuffle_item_t it;
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      go = start;
      if (start && !busy) begin
        apply_item(cur_item);
        go = 1'b0;
        gap_left = steady ? 0 : $urandom_range(0, 6);
      end
      if (!go) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (item_q.size() != 0) begin
          it = item_q.pop_front();
          cur_item = it;
          action   <= it.action;
          position <= it.position;
          char_in  <= it.char_in;
          go = 1'b1;
        end
      end
      start <= go;
    end
  end

  always @(posedge clk) begin : check_chars
    logic [CHAR_W-1:0] want;
    if (!rst && done) begin
      if (char_exp_q.size() == 0) begin
        report($sformatf("char_out %02h with no read outstanding", char_out));
      end else begin
        want = char_exp_q.pop_front();
        reads_checked++;
        if (char_out !== want)
          report($sformatf("char_out %02h, expected %02h", char_out, want));
      end
    end
  end

  initial begin
    #20_000_000;
    $display("run timed out");
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int n_items;
    int r;
    int v;
    logic [DATA_W-1:0] d;
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    action = spp_pkg::ACT_WRITE;
    position = '0;
    char_in = '0;
    cfg_valid = 1'b0;
    cfg_index = spp_pkg::REG_REPEAT_COUNT;
    cfg_data = '0;
    steady = 1'b1;
    gap_left = 0;
    rep_k = '0;
    len_n = 1;
    max_len_seen = 1;
    rebuild_jumps();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset setting: single-byte buffer, identity
    push_write(0, 8'h00);
    push_read(0);
    push_write(0, 8'hFF);
    push_write(1023, 8'hAA);
    push_read(1023);
    push_read(0);
    push_write(1, 8'h55);
    wait_idle();

    // zero length clamps to one; full repeat count
    write_reg(spp_pkg::REG_LENGTH, 31'd0);
    write_reg(spp_pkg::REG_REPEAT_COUNT, 31'h7FFF_FFFF);
    push_read(0);
    push_read(1);
    wait_idle();

    // oversize length clamps to the maximum
    steady = 1'b0;
    write_reg(spp_pkg::REG_LENGTH, 31'h7FF);
    push_write(1023, 8'h80);
    push_read(0);
    push_read(1023);
    push_read(512);
    push_read(511);
    wait_idle();

    write_reg(spp_pkg::REG_REPEAT_COUNT, 31'd0);
    write_reg(spp_pkg::REG_LENGTH, 31'd1024);
    push_read(1023);
    push_read(0);
    wait_idle();

    write_reg(spp_pkg::REG_LENGTH, 31'd7);
    write_reg(spp_pkg::REG_REPEAT_COUNT, 31'd1);
    push_read(3);
    push_read(6);
    push_read(7);
    wait_idle();

    while (items_made < 850) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 6) begin
        if (big_phases < 3 && $urandom_range(0, 7) == 0) begin
          v = $urandom_range(41, 2047);
          big_phases++;
        end else begin
          v = $urandom_range(0, 40);
        end
        d = DATA_W'($urandom);
        d[LEN_W-1:0] = LEN_W'(v);
        write_reg(spp_pkg::REG_LENGTH, d);
      end
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 5))
          0: d = 31'd0;
          1: d = DATA_W'($urandom_range(1, 3));
          2: d = 31'h7FFF_FFFF;
          3: d = DATA_W'($urandom_range(0, 100));
          default: d = DATA_W'($urandom);
        endcase
        write_reg(spp_pkg::REG_REPEAT_COUNT, d);
      end
      n_items = $urandom_range(20, 60);
      repeat (n_items) begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          push_read($urandom_range(0, len_n - 1));
        end else if (r < 85 || len_n >= spp_pkg::MAX_LEN) begin
          push_write($urandom_range(0, len_n - 1), CHAR_W'($urandom_range(0, 255)));
        end else if (r < 93) begin
          push_write($urandom_range(len_n, spp_pkg::MAX_LEN - 1),
                     CHAR_W'($urandom_range(0, 255)));
        end else begin
          push_read($urandom_range(len_n, spp_pkg::MAX_LEN - 1));
        end
      end
      wait_idle();
    end

    $display("covered %0d checked reads and %0d write beats", reads_checked, writes_seen);
    $display("over %0d register writes, buffer lengths up to %0d", reg_writes, max_len_seen);
    if (errs == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/spp_pkg.sv
sv/spp_ram.sv
sv/shuffle_power_permuter.sv
verif/tb_shuffle_power_permuter.sv
